>>> src/brms_pkg.sv
`timescale 1ns / 1ps

package brms_pkg;

    // Block geometry
    localparam int SAMPLE_W    = 12;
    localparam int MAX_SAMPLES = 64;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int ADDR_W      = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

    // Arithmetic widths
    localparam int SUM_W  = SAMPLE_W + CNT_W;
    localparam int PROD_W = 2 * SAMPLE_W;
    localparam int SQ_W   = PROD_W + CNT_W;
    localparam int RAD_W  = SQ_W + (SQ_W % 2);
    localparam int ROOT_W = RAD_W / 2;
    localparam int STEP_W = $clog2(SQ_W);

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } t_in_beat;

    typedef struct packed {
        logic [SAMPLE_W-1:0] rms_value;
        logic [SAMPLE_W-1:0] mean_value;
    } t_out_beat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MLOAD,
        ST_MEAN,
        ST_RD,
        ST_DEV,
        ST_MUL,
        ST_VLOAD,
        ST_VAR,
        ST_SQRT,
        ST_OUT
    } t_state;

endpackage

>>> src/block_rms_of_adc_samples_unit.sv
`timescale 1ns / 1ps

// Channel   Ports                           Direction  Beat taken when
// --------  ------------------------------  ---------  --------------------------------
// sample    i_start, o_busy, i_item         in         rising edge, i_start & !o_busy
// result    o_strobe, o_result              out        rising edge ending strobe cycle
//
// Cycles: a beat without last is taken every cycle while idle. A beat with last
// closes the block; o_busy then stays high through the serial mean division, a
// memory read and bit-serial squaring pass for each of the N stored samples (N up
// to MAX_SAMPLES), the variance division and the two-bit-per-step square root,
// then the result cycle.
// Reset: synchronous, active low; clears the state machine, running sum and count.
// The sample memory has no reset; only entries written in the current block are read.
// Stalls: the receiver cannot stall; the result is shown for exactly one cycle.
module block_rms_of_adc_samples_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  brms_pkg::t_in_beat  i_item,
    output logic                o_busy,
    output logic                o_strobe,
    output brms_pkg::t_out_beat o_result
);
    import brms_pkg::*;

    t_state r_state, n_state;

    // Sample memory, written while collecting, read one entry per sample pass
    logic [SAMPLE_W-1:0] r_mem [MAX_SAMPLES];
    logic [SAMPLE_W-1:0] r_rd_data;

    logic [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_idx;
    logic [STEP_W-1:0]   r_step;

    // Shared restoring divider: dividend shifts out at the top, quotient in at the bottom
    logic [SQ_W-1:0]     r_dvd;
    logic [CNT_W:0]      r_rem;

    logic [SAMPLE_W-1:0] r_mean;
    logic [PROD_W-1:0]   r_mcand;
    logic [SAMPLE_W-1:0] r_mplier;
    logic [SQ_W-1:0]     r_sq;

    // Square root by digit pairs
    logic [RAD_W-1:0]    r_rad;
    logic [ROOT_W+1:0]   r_srem;
    logic [ROOT_W-1:0]   r_root;

    logic                accept;
    logic                step_done;
    logic                last_sample;
    logic [CNT_W:0]      div_sh;
    logic                div_ge;
    logic [CNT_W:0]      div_rem;
    logic [SQ_W-1:0]     div_dvd;
    logic [SAMPLE_W-1:0] dev;
    logic [ROOT_W+1:0]   sq_sh;
    logic [ROOT_W+1:0]   sq_trial;
    logic                sq_ge;

    assign accept      = i_start && !o_busy;
    assign step_done   = (r_step == '0);
    assign last_sample = ((r_idx + CNT_W'(1)) == r_count);

    // One divider step: bring down the next dividend bit, subtract if it fits
    always_comb begin
        div_sh  = {r_rem[CNT_W-1:0], r_dvd[SQ_W-1]};
        div_ge  = (div_sh >= {1'b0, r_count});
        div_rem = div_ge ? (div_sh - {1'b0, r_count}) : div_sh;
        div_dvd = {r_dvd[SQ_W-2:0], div_ge};
    end

    // Absolute deviation of the fetched sample from the mean
    assign dev = (r_rd_data >= r_mean) ? (r_rd_data - r_mean) : (r_mean - r_rd_data);

    // One root step: bring down two radicand bits, try (root << 2) | 1
    always_comb begin
        sq_sh    = {r_srem[ROOT_W-1:0], r_rad[RAD_W-1 -: 2]};
        sq_trial = {r_root, 2'b01};
        sq_ge    = (sq_sh >= sq_trial);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (accept && i_item.last) n_state = ST_MLOAD;
            ST_MLOAD: n_state = ST_MEAN;
            ST_MEAN:  if (step_done) n_state = ST_RD;
            ST_RD:    n_state = ST_DEV;
            ST_DEV:   n_state = ST_MUL;
            ST_MUL: begin
                if (step_done) n_state = last_sample ? ST_VLOAD : ST_RD;
            end
            ST_VLOAD: n_state = ST_VAR;
            ST_VAR:   if (step_done) n_state = ST_SQRT;
            ST_SQRT:  if (step_done) n_state = ST_OUT;
            ST_OUT:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_busy              = (r_state != ST_IDLE);
        o_strobe            = (r_state == ST_OUT);
        o_result.rms_value  = r_root[SAMPLE_W-1:0];
        o_result.mean_value = r_mean;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Memory: write on a stored sample beat, registered read at the pass index
    always_ff @(posedge i_clk) begin
        if (accept && (r_count < CNT_W'(MAX_SAMPLES))) begin
            r_mem[r_count[ADDR_W-1:0]] <= i_item.sample;
        end
        r_rd_data <= r_mem[r_idx[ADDR_W-1:0]];
    end

    // Running sum and count: control state, cleared by reset and after each result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (r_state == ST_OUT) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (accept && (r_count < CNT_W'(MAX_SAMPLES))) begin
            r_sum   <= r_sum + SUM_W'(i_item.sample);
            r_count <= r_count + CNT_W'(1);
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_MLOAD: begin
                r_dvd  <= SQ_W'(r_sum);
                r_rem  <= '0;
                r_step <= STEP_W'(SQ_W - 1);
            end
            ST_MEAN: begin
                r_dvd  <= div_dvd;
                r_rem  <= div_rem;
                r_step <= r_step - STEP_W'(1);
                if (step_done) begin
                    r_mean <= div_dvd[SAMPLE_W-1:0];
                    r_idx  <= '0;
                    r_sq   <= '0;
                end
            end
            ST_DEV: begin
                r_mcand  <= PROD_W'(dev);
                r_mplier <= dev;
                r_step   <= STEP_W'(SAMPLE_W - 1);
            end
            ST_MUL: begin
                // Shift-add squaring straight into the accumulator
                if (r_mplier[0]) begin
                    r_sq <= r_sq + SQ_W'(r_mcand);
                end
                r_mcand  <= {r_mcand[PROD_W-2:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[SAMPLE_W-1:1]};
                r_step   <= r_step - STEP_W'(1);
                if (step_done) begin
                    r_idx <= r_idx + CNT_W'(1);
                end
            end
            ST_VLOAD: begin
                r_dvd  <= r_sq;
                r_rem  <= '0;
                r_step <= STEP_W'(SQ_W - 1);
            end
            ST_VAR: begin
                r_dvd  <= div_dvd;
                r_rem  <= div_rem;
                if (step_done) begin
                    r_rad  <= RAD_W'(div_dvd);
                    r_srem <= '0;
                    r_root <= '0;
                    r_step <= STEP_W'(ROOT_W - 1);
                end else begin
                    r_step <= r_step - STEP_W'(1);
                end
            end
            ST_SQRT: begin
                r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
                r_srem <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
                r_root <= {r_root[ROOT_W-2:0], sq_ge};
                r_step <= r_step - STEP_W'(1);
            end
            default: begin
                // hold
            end
        endcase
    end

    // Checks
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for more than one cycle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SAMPLES))
        else $error("sample count beyond memory depth");

    a_last_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.last) |=> o_busy)
        else $error("closing beat did not start computation");

    a_plain_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_item.last) |=> !o_busy)
        else $error("plain sample beat left the block busy");

    a_pass_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> (r_idx < r_count))
        else $error("squaring pass beyond stored samples");

endmodule

>>> test/tb_block_rms_of_adc_samples_unit.sv
`timescale 1ns / 1ps

module tb_block_rms_of_adc_samples_unit;
    import brms_pkg::*;

    // Run shape
    localparam int ITEM_GOAL    = 650;
    localparam int BLOCK_GOAL   = 40;
    localparam int CALM_TAIL    = 80;
    // Longest busy stretch: mean and variance divisions, a read and squaring pass per stored sample,
    // square root and the result cycle.
    localparam int BUSY_MAX     = 81 + 14 * MAX_SAMPLES + 1;
    localparam int DRAIN_CYCLES = BUSY_MAX + 20;
    localparam int STALL_LIMIT  = 5 * BUSY_MAX;
    localparam int N_DIRECTED   = 15;

    // Sample shapes for random blocks
    typedef enum int {
        SPREAD_FULL,
        SPREAD_NARROW,
        SPREAD_RAILS,
        SPREAD_LOW
    } t_spread;

    // One row of the directed table; typed rows carry their own expected result
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
        logic                typed;
        logic [SAMPLE_W-1:0] rms_value;
        logic [SAMPLE_W-1:0] mean_value;
    } t_dir_row;

    // Directed table: single-sample blocks at both rails, the widest possible spread,
    // a flat block at full scale, alternating bit patterns and a small ramp.
    const t_dir_row directed_rows [N_DIRECTED] = '{
        '{12'h000, 1'b1, 1'b1, 12'd0,    12'd0},     // block of one, all zeros
        '{12'hFFF, 1'b1, 1'b1, 12'd0,    12'd4095},  // block of one, full scale
        '{12'h000, 1'b0, 1'b0, 12'd0,    12'd0},
        '{12'hFFF, 1'b1, 1'b1, 12'd2047, 12'd2047},  // rail to rail, largest deviation
        '{12'hFFF, 1'b0, 1'b0, 12'd0,    12'd0},
        '{12'hFFF, 1'b1, 1'b1, 12'd0,    12'd4095},  // flat at full scale
        '{12'hAAA, 1'b0, 1'b0, 12'd0,    12'd0},
        '{12'h555, 1'b1, 1'b0, 12'd0,    12'd0},
        '{12'h800, 1'b0, 1'b0, 12'd0,    12'd0},
        '{12'h7FF, 1'b1, 1'b0, 12'd0,    12'd0},
        '{12'h064, 1'b0, 1'b0, 12'd0,    12'd0},
        '{12'h0C8, 1'b0, 1'b0, 12'd0,    12'd0},
        '{12'h12C, 1'b0, 1'b0, 12'd0,    12'd0},
        '{12'h190, 1'b1, 1'b0, 12'd0,    12'd0},
        '{12'h001, 1'b1, 1'b1, 12'd0,    12'd1}      // block of one, smallest non-zero
    };

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_start = 1'b0;
    t_in_beat  i_item  = '0;
    logic      o_busy;
    logic      o_strobe;
    t_out_beat o_result;

    // Predictor copy of the block being collected
    logic [SAMPLE_W-1:0] held_samples [MAX_SAMPLES];
    int unsigned         held_sum   = 0;
    int unsigned         held_count = 0;

    // Results owed by the block, oldest first
    t_out_beat   rms_mean_due [$];
    int unsigned mismatch_count = 0;
    int unsigned items_sent     = 0;
    int unsigned blocks_closed  = 0;
    int unsigned quiet_cycles   = 0;

    block_rms_of_adc_samples_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // AC RMS and truncated mean over the samples held for the current block.
    function automatic t_out_beat block_rms_mean();
        t_out_beat         res;
        int unsigned       mean;
        int unsigned       dev;
        longint unsigned   sq_sum;
        longint unsigned   var_q;
        longint unsigned   trial;
        int unsigned       root;
        mean   = held_sum / held_count;
        sq_sum = 0;
        for (int i = 0; i < held_count; i++) begin
            dev    = (held_samples[i] >= mean) ? held_samples[i] - mean : mean - held_samples[i];
            sq_sum += longint'(dev) * dev;
        end
        var_q = sq_sum / held_count;
        // Build the floor square root one bit at a time, most significant first
        root = 0;
        for (int b = 15; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if (trial * trial <= var_q) begin
                root = int'(trial);
            end
        end
        res.rms_value  = root[SAMPLE_W-1:0];
        res.mean_value = mean[SAMPLE_W-1:0];
        return res;
    endfunction

    // Fold an accepted beat into the predictor; on the closing beat, queue the result.
    task automatic fold_beat(input t_in_beat beat, input bit typed, input t_out_beat typed_res);
        items_sent++;
        // Drop samples once the store is full; a closing beat still closes the block
        if (held_count < MAX_SAMPLES) begin
            held_samples[held_count] = beat.sample;
            held_sum   += beat.sample;
            held_count++;
        end
        if (beat.last) begin
            rms_mean_due.push_back(typed ? typed_res : block_rms_mean());
            held_sum   = 0;
            held_count = 0;
            blocks_closed++;
        end
    endtask

    // Offer one beat and hold it until the block takes it.
    task automatic drive_beat(input t_in_beat beat, input bit typed, input t_out_beat typed_res);
        i_start <= 1'b1;
        i_item  <= beat;
        do @(posedge i_clk); while (o_busy);
        fold_beat(beat, typed, typed_res);
    endtask

    // Drop start for a number of cycles.
    task automatic rest(input int unsigned cycles);
        i_start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(input t_spread spread,
                                                        input logic [SAMPLE_W-1:0] centre);
        int v;
        case (spread)
            SPREAD_NARROW: begin
                v = int'(centre) + int'($urandom_range(0, 14)) - 7;
                if (v < 0) begin
                    v = 0;
                end else if (v > 4095) begin
                    v = 4095;
                end
                return v[SAMPLE_W-1:0];
            end
            SPREAD_RAILS:  return $urandom_range(0, 1) ? '1 : '0;
            SPREAD_LOW:    return SAMPLE_W'($urandom_range(0, 15));
            default:       return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Check each result beat against the oldest owed result, and watch for a hang:
    // a cycle counts as quiet when neither a sample nor a result beat is taken.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n) begin
            if ((i_start && !o_busy) || o_strobe) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (o_strobe) begin
                if (rms_mean_due.size() == 0) begin
                    $error("unexpected result: rms_value %0d, mean_value %0d",
                           o_result.rms_value, o_result.mean_value);
                    mismatch_count++;
                end else begin
                    want = rms_mean_due.pop_front();
                    if (o_result.rms_value !== want.rms_value) begin
                        $error("rms_value: expected %0d, got %0d",
                               want.rms_value, o_result.rms_value);
                        mismatch_count++;
                    end
                    if (o_result.mean_value !== want.mean_value) begin
                        $error("mean_value: expected %0d, got %0d",
                               want.mean_value, o_result.mean_value);
                        mismatch_count++;
                    end
                end
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        t_in_beat    beat;
        t_out_beat   row_res;
        t_spread     spread;
        logic [SAMPLE_W-1:0] centre;
        int unsigned blk_len;
        int unsigned blk_idx;
        int unsigned pick;
        bit          calm;

        // Hold reset, then release it once
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table, idling now and then between beats
        for (int r = 0; r < N_DIRECTED; r++) begin
            if ($urandom_range(0, 3) == 0) begin
                rest($urandom_range(1, 11));
            end
            beat.sample        = directed_rows[r].sample;
            beat.last          = directed_rows[r].last;
            row_res.rms_value  = directed_rows[r].rms_value;
            row_res.mean_value = directed_rows[r].mean_value;
            drive_beat(beat, directed_rows[r].typed, row_res);
        end

        // Random blocks: mostly short, a few that fill the store exactly or overflow it
        blk_idx = 0;
        while (items_sent < ITEM_GOAL || blocks_closed < BLOCK_GOAL) begin
            case (blk_idx)
                1:       blk_len = MAX_SAMPLES;
                3:       blk_len = MAX_SAMPLES + 1;
                default: begin
                    pick = $urandom_range(0, 99);
                    if (pick < 85) begin
                        blk_len = $urandom_range(1, 12);
                    end else if (pick < 97) begin
                        blk_len = $urandom_range(13, MAX_SAMPLES - 1);
                    end else begin
                        blk_len = $urandom_range(MAX_SAMPLES, MAX_SAMPLES + 16);
                    end
                end
            endcase
            spread = t_spread'($urandom_range(0, 3));
            centre = SAMPLE_W'($urandom);
            calm   = ($urandom_range(0, 2) == 0);

            for (int unsigned k = 0; k < blk_len; k++) begin
                // Idle in bursts, except in calm blocks and over the tail of the run
                if (!calm && items_sent < ITEM_GOAL - CALM_TAIL
                        && $urandom_range(0, 3) == 0) begin
                    rest($urandom_range(1, 11));
                end
                beat.sample = pick_sample(spread, centre);
                beat.last   = (k == blk_len - 1);
                drive_beat(beat, 1'b0, '0);
            end

            // Once, hold off until the block has delivered everything owed
            if (blk_idx == 4) begin
                i_start <= 1'b0;
                while (rms_mean_due.size() != 0) @(posedge i_clk);
            end
            blk_idx++;
        end

        // Drain: wait for owed results, then linger to catch any stray beat
        i_start <= 1'b0;
        while (rms_mean_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> files.f
src/brms_pkg.sv
src/block_rms_of_adc_samples_unit.sv
test/tb_block_rms_of_adc_samples_unit.sv
